// File: hw/rtl/mrtr_pkg.sv
// shared types, constants and register codes of the multi-rule text replace unit
package mrtr_pkg;

  localparam int MaxPatternBytes = 8;
  localparam int RuleCount       = 2;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 64;
  localparam int LenW            = 4;
  localparam int SubstMaxBytes   = 8;

  // register codes within one rule, low two bits of the register index
  localparam logic [1:0] REG_PATTERN     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LEN = 2'd1;
  localparam logic [1:0] REG_SUBST       = 2'd2;
  localparam logic [1:0] REG_SUBST_LEN   = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
  } out_res_t;

  typedef struct packed {
    logic [CfgDataW-1:0] pattern;
    logic [LenW-1:0]     pattern_len;
    logic [CfgDataW-1:0] subst;
    logic [LenW-1:0]     subst_len;
  } rule_t;

endpackage

// File: hw/rtl/multi_rule_text_replace_unit.sv
// top level of the multi-rule streaming text find-and-replace unit
// Streaming find-and-replace over a byte text. Text bytes are taken one per
// cycle into a row of MAX_PATTERN_BYTES window cells until the window is full
// or the byte flagged as final arrives. Then a decision is made at the window
// head: rules are tried in order and the first whose pattern equals the
// leading bytes wins; its replacement bytes go out and the matched bytes are
// shifted out of the cell row, one cell position per cycle. Without a match
// the head byte passes through. A full-window decision runs a decide, an emit
// and a shift step, the shift dropping D bytes (D at least 1). Text bytes are
// taken only while the window fills, not during a decision, so the sustained
// cost is set by the sequencer walking each decision through the emit and
// shift steps. On the final byte the window drains through repeated decisions
// and a closing step marks the last result with out_end; when the final
// request yields no byte, a single end-only result (out_valid 0) is sent.
// Output backpressure stalls the emit and closing steps. Rules are written on
// the config channel (index 4*rule + {pattern, pattern_len, subst, subst_len})
// only while idle, a rule on the user; the block itself does not enforce it.
module multi_rule_text_replace_unit import mrtr_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MaxPatternBytes,
  parameter int RULE_COUNT        = RuleCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // text input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_req_t             in_req_i,
  // rewritten text output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_res_t            out_res_o,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int FillW = $clog2(MAX_PATTERN_BYTES + 1);

  // sequencer states
  localparam logic [2:0] ST_FILL   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_DROP   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // rule registers
  rule_t rules [RULE_COUNT];

  assign cfg_ready_o = 1'b1;

  mrtr_cfg_regs #(
    .RULE_COUNT (RULE_COUNT)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rules_o     (rules)
  );

  // control state
  logic [2:0]       state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] drop_q, drop_d;
  logic             drain_q, drain_d;
  logic             pend_v_q, pend_v_d;
  logic             out_v_q, out_v_d;
  // payload state
  logic [LenW-1:0]     em_idx_q, em_idx_d;
  logic [LenW-1:0]     em_cnt_q, em_cnt_d;
  logic [CfgDataW-1:0] subst_q, subst_d;
  logic [7:0]          pend_q, pend_d;
  out_res_t            out_q, out_d;

  logic in_fire;
  logic push_ok;

  assign in_ready_o = (state_q == ST_FILL);
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_ok    = !out_v_q || out_ready_i;

  // window cell row, cell 0 is the head
  logic [7:0]                        win_byte [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0][RULE_COUNT-1:0] cell_eq;
  logic                              shift_en;

  assign shift_en = (state_q == ST_DROP);

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [RULE_COUNT-1:0][7:0] pat_bytes;
    logic [7:0]                 next_byte;

    for (genvar r = 0; r < RULE_COUNT; r++) begin : g_pat
      assign pat_bytes[r] = rules[r].pattern[8*k +: 8];
    end

    // the tail cell has no right neighbor, its stale byte lies beyond the fill
    if (k == MAX_PATTERN_BYTES - 1) begin : g_tail
      assign next_byte = win_byte[k];
    end else begin : g_mid
      assign next_byte = win_byte[k+1];
    end

    mrtr_cell #(
      .RULE_COUNT (RULE_COUNT)
    ) u_cell (
      .clk_i       (clk_i),
      .load_i      (in_fire && (fill_q == FillW'(k))),
      .shift_i     (shift_en),
      .load_byte_i (in_req_i.text_byte),
      .next_byte_i (next_byte),
      .pat_byte_i  (pat_bytes),
      .data_o      (win_byte[k]),
      .eq_o        (cell_eq[k])
    );
  end

  // per-rule match at the window head
  logic [RULE_COUNT-1:0] rule_hit;

  always_comb begin
    for (int r = 0; r < RULE_COUNT; r++) begin
      logic all_eq;
      all_eq = 1'b1;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        if ((LenW'(k) < rules[r].pattern_len) && !cell_eq[k][r]) begin
          all_eq = 1'b0;
        end
      end
      // empty, oversized, or longer-than-held patterns never match
      rule_hit[r] = (rules[r].pattern_len != '0) &&
                    (rules[r].pattern_len <= LenW'(MAX_PATTERN_BYTES)) &&
                    (rules[r].pattern_len <= LenW'(fill_q)) &&
                    all_eq;
    end
  end

  // first matching rule wins, else head byte passes through
  logic                dec_hit;
  logic [CfgDataW-1:0] dec_subst;
  logic [LenW-1:0]     dec_slen;
  logic [LenW-1:0]     dec_plen;

  always_comb begin
    dec_hit   = 1'b0;
    dec_subst = {{(CfgDataW-8){1'b0}}, win_byte[0]};
    dec_slen  = LenW'(1);
    dec_plen  = LenW'(1);
    for (int r = RULE_COUNT - 1; r >= 0; r--) begin
      if (rule_hit[r]) begin
        dec_hit   = 1'b1;
        dec_subst = rules[r].subst;
        dec_slen  = (rules[r].subst_len > LenW'(SubstMaxBytes)) ?
                    LenW'(SubstMaxBytes) : rules[r].subst_len;
        dec_plen  = rules[r].pattern_len;
      end
    end
  end

  logic [7:0] em_byte;
  assign em_byte = subst_q[{em_idx_q[2:0], 3'b000} +: 8];

  // sequencer
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    drain_d  = drain_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    em_idx_d = em_idx_q;
    em_cnt_d = em_cnt_q;
    subst_d  = subst_q;
    out_d    = out_q;
    out_v_d  = out_v_q;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          fill_d = fill_q + FillW'(1);
          if (in_req_i.text_end) begin
            drain_d = 1'b1;
            state_d = ST_DECIDE;
          end else if (fill_q == FillW'(MAX_PATTERN_BYTES - 1)) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (fill_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          subst_d  = dec_subst;
          em_cnt_d = dec_slen;
          drop_d   = FillW'(dec_plen);
          em_idx_d = '0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (em_idx_q == em_cnt_q) begin
          state_d = ST_DROP;
        end else if (drain_q) begin
          // while draining, hold one byte back so the last one can carry the end flag
          if (!pend_v_q) begin
            pend_d   = em_byte;
            pend_v_d = 1'b1;
            em_idx_d = em_idx_q + LenW'(1);
          end else if (push_ok) begin
            out_d    = '{out_byte: pend_q, out_valid: 1'b1, out_end: 1'b0};
            out_v_d  = 1'b1;
            pend_d   = em_byte;
            em_idx_d = em_idx_q + LenW'(1);
          end
        end else if (push_ok) begin
          out_d    = '{out_byte: em_byte, out_valid: 1'b1, out_end: 1'b0};
          out_v_d  = 1'b1;
          em_idx_d = em_idx_q + LenW'(1);
        end
      end
      ST_DROP: begin
        fill_d = fill_q - FillW'(1);
        drop_d = drop_q - FillW'(1);
        if (drop_q == FillW'(1)) begin
          state_d = drain_q ? ST_DECIDE : ST_FILL;
        end
      end
      ST_FINISH: begin
        if (push_ok) begin
          if (pend_v_q) begin
            out_d = '{out_byte: pend_q, out_valid: 1'b1, out_end: 1'b1};
          end else begin
            out_d = '{out_byte: 8'd0, out_valid: 1'b0, out_end: 1'b1};
          end
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          drain_d  = 1'b0;
          state_d  = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      fill_q   <= '0;
      drop_q   <= '0;
      drain_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      drain_q  <= drain_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_idx_q <= em_idx_d;
    em_cnt_q <= em_cnt_d;
    subst_q  <= subst_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  // window never holds more bytes than it has cells
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MAX_PATTERN_BYTES))
    else $error("window fill above cell count");

  // a held-back byte never survives into the next text
  a_no_pend_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !pend_v_q)
    else $error("pending byte left while collecting text");

  // a shift step always removes a held byte
  a_drop_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DROP) |-> ((drop_q != '0) && (drop_q <= fill_q)))
    else $error("drop count exceeds window fill");

  // a full window without end flag goes straight to a decision
  a_full_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_req_i.text_end && (fill_q == FillW'(MAX_PATTERN_BYTES - 1)))
    |=> (state_q == ST_DECIDE))
    else $error("full window did not start a decision");

endmodule

// File: hw/rtl/mrtr_cell.sv
// one lookahead window cell: holds a byte, loads or shifts, compares against rule bytes
module mrtr_cell import mrtr_pkg::*; #(
  parameter int RULE_COUNT = RuleCount
) (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      shift_i,
  input  logic [7:0]                load_byte_i,
  input  logic [7:0]                next_byte_i,
  input  logic [RULE_COUNT-1:0][7:0] pat_byte_i,
  output logic [7:0]                data_o,
  output logic [RULE_COUNT-1:0]     eq_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_byte_i;
    end else if (shift_i) begin
      data_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_cmp
    assign eq_o[r] = (data_q == pat_byte_i[r]);
  end

  assign data_o = data_q;

endmodule

// File: hw/rtl/mrtr_cfg_regs.sv
// rule register file written through the configuration channel
module mrtr_cfg_regs import mrtr_pkg::*; #(
  parameter int RULE_COUNT = RuleCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output rule_t               rules_o [RULE_COUNT]
);

  rule_t rules_q [RULE_COUNT];
  rule_t rules_d [RULE_COUNT];

  always_comb begin
    for (int r = 0; r < RULE_COUNT; r++) begin
      rules_d[r] = rules_q[r];
      if (cfg_valid_i && (cfg_index_i[CfgIdxW-1] == 1'(r))) begin
        case (cfg_index_i[1:0])
          REG_PATTERN:     rules_d[r].pattern     = cfg_data_i;
          REG_PATTERN_LEN: rules_d[r].pattern_len = cfg_data_i[LenW-1:0];
          REG_SUBST:       rules_d[r].subst       = cfg_data_i;
          REG_SUBST_LEN:   rules_d[r].subst_len   = cfg_data_i[LenW-1:0];
          default:         rules_d[r]             = rules_q[r];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RULE_COUNT; r++) begin
        rules_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < RULE_COUNT; r++) begin
        rules_q[r] <= rules_d[r];
      end
    end
  end

  assign rules_o = rules_q;

endmodule
